### rtl/core/mi4_pkg.sv
// Shared types, codes and helpers for the 4x4 matrix inverse.
// Used by the front loader, the matrix queue and the back sequencer.
package mi4_pkg;

	localparam int DIG = 16;

	typedef enum logic [3:0] {
		B_IDLE,
		B_FX,
		B_FY,
		B_MUL,
		B_WAIT,
		B_NEXT,
		B_DSET,
		B_DOVF,
		B_DIV,
		B_DRND
	} back_state_t;

	typedef enum logic [1:0] {
		PH_D1,
		PH_D2,
		PH_T,
		PH_DET
	} phase_t;

	typedef struct packed {
		logic       en;
		logic [3:0] addr;
		logic       commit;
	} qwr_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	function automatic logic [1:0] other_idx(input logic [1:0] skip, input logic [1:0] n);
		return (n < skip) ? n : n + 2'd1;
	endfunction

endpackage

### rtl/core/matrix_inverse_4x4.sv
// 4x4 fixed-point matrix inverse by cofactors: loader, two-slot matrix queue, back sequencer.
// Input: one element per cycle unless the queue is full; after the sixteenth, the back runs
// 48 cofactor terms (a 2x2 product pair, then a multiply into the cofactor), 4 determinant
// steps, and then a restoring division for each of the 16 output elements.
// Throughput is set by the single digit-serial multiplier and the one-bit-a-cycle divider.
// Reset (arst_n low) empties the queue and the output register; stored elements are kept.
module matrix_inverse_4x4 import mi4_pkg::*; #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // elem_value[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_value[31:0]
	output logic        m_tuser,  // singular
	output logic        m_tlast
);

	qwr_t                  wr;
	qstat_t                stat;
	logic [ELEM_WIDTH-1:0] wr_data;
	logic [ELEM_WIDTH-1:0] rd_data;
	logic [3:0]            rd_addr;
	logic                  pop;

	mi4_front #(.ELEM_WIDTH(ELEM_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .stat(stat), .wr(wr), .wr_data(wr_data)
	);

	mi4_queue #(.ELEM_WIDTH(ELEM_WIDTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr(wr), .wr_data(wr_data), .rd_addr(rd_addr),
		.pop(pop), .stat(stat), .rd_data(rd_data)
	);

	mi4_back #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .stat(stat), .rd_addr(rd_addr), .rd_data(rd_data),
		.pop(pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule

### rtl/core/mi4_front.sv
// Input side: accepts matrix elements and writes them into the queue tail slot.
// Depends on mi4_pkg.
module mi4_front import mi4_pkg::*; #(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,  // elem_value[31:0]
	input  qstat_t                stat,
	output qwr_t                  wr,
	output logic [ELEM_WIDTH-1:0] wr_data
);

	logic [3:0]  load_q;
	logic [63:0] in64;
	logic        acc;

	assign s_tready = !stat.full;
	assign acc      = s_tvalid && s_tready;
	assign in64     = {32'd0, s_tdata};
	assign wr_data  = in64[ELEM_WIDTH-1:0];

	always_comb begin
		wr.en     = acc;
		wr.addr   = load_q;
		wr.commit = acc && (load_q == 4'd15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q <= 4'd0;
		end else if (acc) begin
			load_q <= load_q + 4'd1;
		end
	end

endmodule

### rtl/core/mi4_queue.sv
// Two-slot matrix queue between the front loader and the back sequencer.
// Depends on mi4_pkg.
module mi4_queue import mi4_pkg::*; #(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qwr_t                  wr,
	input  logic [ELEM_WIDTH-1:0] wr_data,
	input  logic [3:0]            rd_addr,
	input  logic                  pop,
	output qstat_t                stat,
	output logic [ELEM_WIDTH-1:0] rd_data
);

	logic [ELEM_WIDTH-1:0] slot_q [2][16];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            cnt_q;

	assign rd_data = slot_q[rd_ptr_q][rd_addr];

	always_comb begin
		stat.empty = (cnt_q == 2'd0);
		stat.full  = (cnt_q == 2'd2);
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			slot_q[wr_ptr_q][wr.addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr.commit) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr.commit} - {1'b0, pop};
		end
	end

endmodule

### rtl/core/mi4_back.sv
// Back side: cofactors and determinant on a shared digit-serial multiply-accumulate,
// then a restoring divider per inverse element and the output register. Uses mi4_pkg.
module mi4_back import mi4_pkg::*; #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qstat_t                stat,
	output logic [3:0]            rd_addr,
	input  logic [ELEM_WIDTH-1:0] rd_data,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,  // out_value[31:0]
	output logic                  m_tuser,  // singular
	output logic                  m_tlast
);

	localparam int W    = ELEM_WIDTH;
	localparam int TW   = 2 * W + 1;
	localparam int CW   = 3 * W + 3;
	localparam int DW   = 4 * W + 5;
	localparam int NDE  = (W + DIG - 1) / DIG;
	localparam int NDT  = (TW + DIG - 1) / DIG;
	localparam int NDC  = (CW + DIG - 1) / DIG;
	localparam int YPW  = DIG * NDC;
	localparam int KW   = (NDC > 1) ? $clog2(NDC) : 1;
	localparam int PW   = W + DIG + 1;
	localparam int AW   = DW;
	localparam int NW   = CW + 2 * FRAC_BITS;
	localparam int DVW  = ((NW > DW) ? NW : DW) + W + 3;
	localparam int QB   = W + 2;
	localparam int QW   = W + 3;
	localparam int QCW  = $clog2(QB);

	back_state_t state_q, state_d;
	phase_t      phase_q;
	logic [1:0]  term_q;
	logic [3:0]  cidx_q;
	logic [KW-1:0] kcnt_q;
	logic [3:0]  oidx_q;
	logic [QCW-1:0] dcnt_q;
	logic        pv_s1;
	logic        ovalid_q;

	logic signed [W-1:0]  x_q;
	logic [YPW-1:0]       y_q;
	logic [TW-1:0]        tacc_q;
	logic [AW-1:0]        acc_q;
	logic [CW-1:0]        cof_q [16];
	logic [DW-1:0]        det_q;
	logic signed [PW-1:0] prod_s1;
	logic [KW-1:0]        shf_s1;
	logic                 neg_s1;
	logic                 tgt_s1;
	logic [DVW-1:0]       rem_q;
	logic [DVW-1:0]       dsh_q;
	logic [QW-1:0]        q_q;
	logic                 sat_q;
	logic                 qneg_q;
	logic [31:0]          oval_q;
	logic                 osing_q;
	logic                 olast_q;

	logic [1:0] ci, cj, r0, r1, r2, c0, c1, c2, ck, ca, cb;
	logic [KW-1:0] klast;
	logic          ktop;
	logic [DIG-1:0] yd;
	logic signed [DIG:0] dig;
	logic          mneg;
	logic signed [AW-1:0] pext, base, ext, sum;
	logic [CW-1:0] acof, amag;
	logic [DW-1:0] dmag;
	logic          sing;
	logic          rnd;
	logic [QW-1:0] qr, lim, resq;
	logic [W-1:0]  res;
	logic [63:0]   res64;
	logic          out_load;
	logic          div_ge;

	assign ci = cidx_q[3:2];
	assign cj = cidx_q[1:0];
	assign r0 = other_idx(ci, 2'd0);
	assign r1 = other_idx(ci, 2'd1);
	assign r2 = other_idx(ci, 2'd2);
	assign c0 = other_idx(cj, 2'd0);
	assign c1 = other_idx(cj, 2'd1);
	assign c2 = other_idx(cj, 2'd2);
	assign ck = (term_q == 2'd0) ? c0 : ((term_q == 2'd1) ? c1 : c2);
	assign ca = (term_q == 2'd0) ? c1 : c0;
	assign cb = (term_q == 2'd2) ? c1 : c2;

	always_comb begin
		rd_addr = 4'd0;
		unique case (phase_q)
			PH_D1:  rd_addr = (state_q == B_FY) ? {cb, r2} : {ca, r1};
			PH_D2:  rd_addr = (state_q == B_FY) ? {ca, r2} : {cb, r1};
			PH_T:   rd_addr = {ck, r0};
			PH_DET: rd_addr = {2'b00, cj};
			default: rd_addr = 4'd0;
		endcase
	end

	always_comb begin
		klast = KW'(NDC - 1);
		mneg  = 1'b0;
		unique case (phase_q)
			PH_D1: begin
				klast = KW'(NDE - 1);
			end
			PH_D2: begin
				klast = KW'(NDE - 1);
				mneg  = 1'b1;
			end
			PH_T: begin
				klast = KW'(NDT - 1);
				mneg  = (term_q == 2'd1) ^ ci[0] ^ cj[0];
			end
			PH_DET: begin
				klast = KW'(NDC - 1);
			end
			default: klast = KW'(NDC - 1);
		endcase
	end

	assign ktop = (kcnt_q == klast);
	assign yd   = y_q[kcnt_q * DIG +: DIG];
	assign dig  = {ktop & yd[DIG-1], yd};

	assign pext = AW'(prod_s1);
	assign ext  = pext << (DIG * shf_s1);
	assign base = tgt_s1 ? $signed(acc_q) : AW'($signed(tacc_q));
	assign sum  = neg_s1 ? (base - ext) : (base + ext);

	assign acof   = cof_q[oidx_q];
	assign amag   = acof[CW-1] ? (~acof + CW'(1)) : acof;
	assign dmag   = det_q[DW-1] ? (~det_q + DW'(1)) : det_q;
	assign sing   = (det_q == '0);
	assign div_ge = (rem_q >= dsh_q);

	assign rnd = ({rem_q[DVW-2:0], 1'b0} >= DVW'(dmag));
	assign qr  = q_q + QW'(rnd);
	assign lim = QW'(1) << (W - 1);
	always_comb begin
		if (!qneg_q) begin
			resq = (sat_q || (qr >= lim)) ? (lim - QW'(1)) : qr;
		end else begin
			resq = (sat_q || (qr > lim)) ? (~lim + QW'(1)) : (~qr + QW'(1));
		end
		res = sing ? '0 : resq[W-1:0];
	end
	assign res64 = 64'($signed(res));

	assign out_load = (state_q == B_DRND) && (!ovalid_q || m_tready);
	assign pop = (state_q == B_NEXT) && (phase_q == PH_DET) && (cj == 2'd3);

	assign m_tvalid = ovalid_q;
	assign m_tdata  = oval_q;
	assign m_tuser  = osing_q;
	assign m_tlast  = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!stat.empty) state_d = B_FX;
			B_FX:   state_d = B_FY;
			B_FY:   state_d = B_MUL;
			B_MUL:  if (ktop) state_d = B_WAIT;
			B_WAIT: state_d = B_NEXT;
			B_NEXT: state_d = pop ? B_DSET : B_FX;
			B_DSET: state_d = sing ? B_DRND : B_DOVF;
			B_DOVF: state_d = B_DIV;
			B_DIV:  if (dcnt_q == '0) state_d = B_DRND;
			B_DRND: begin
				if (out_load) begin
					state_d = (oidx_q == 4'd15) ? B_IDLE : B_DSET;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_D1;
			term_q   <= 2'd0;
			cidx_q   <= 4'd0;
			kcnt_q   <= '0;
			oidx_q   <= 4'd0;
			dcnt_q   <= '0;
			pv_s1    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			pv_s1 <= (state_q == B_MUL);
			case (state_q)
				B_IDLE: begin
					phase_q <= PH_D1;
					term_q  <= 2'd0;
					cidx_q  <= 4'd0;
					oidx_q  <= 4'd0;
				end
				B_FY:  kcnt_q <= '0;
				B_MUL: kcnt_q <= kcnt_q + KW'(1);
				B_NEXT: begin
					case (phase_q)
						PH_D1: phase_q <= PH_D2;
						PH_D2: phase_q <= PH_T;
						PH_T: begin
							phase_q <= PH_D1;
							if (term_q != 2'd2) begin
								term_q <= term_q + 2'd1;
							end else begin
								term_q <= 2'd0;
								cidx_q <= cidx_q + 4'd1;
								if (cidx_q == 4'd15) begin
									phase_q <= PH_DET;
								end
							end
						end
						default: cidx_q <= cidx_q + 4'd1;
					endcase
				end
				B_DOVF: dcnt_q <= QCW'(QB - 1);
				B_DIV:  dcnt_q <= dcnt_q - QCW'(1);
				B_DRND: if (out_load) oidx_q <= oidx_q + 4'd1;
				default: ;
			endcase
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pv_s1) begin
			if (tgt_s1) begin
				acc_q <= sum;
			end else begin
				tacc_q <= sum[TW-1:0];
			end
		end
		case (state_q)
			B_FX: x_q <= $signed(rd_data);
			B_FY: begin
				unique case (phase_q)
					PH_D1: begin
						y_q    <= YPW'($signed(rd_data));
						tacc_q <= '0;
					end
					PH_D2: y_q <= YPW'($signed(rd_data));
					PH_T: begin
						y_q <= YPW'($signed(tacc_q));
						if (term_q == 2'd0) acc_q <= '0;
					end
					PH_DET: begin
						y_q <= YPW'($signed(cof_q[{cj, 2'b00}]));
						if (cj == 2'd0) acc_q <= '0;
					end
					default: y_q <= '0;
				endcase
			end
			B_MUL: begin
				prod_s1 <= x_q * dig;
				shf_s1  <= kcnt_q;
				neg_s1  <= mneg;
				tgt_s1  <= (phase_q == PH_T) || (phase_q == PH_DET);
			end
			B_NEXT: begin
				if ((phase_q == PH_T) && (term_q == 2'd2)) cof_q[cidx_q] <= acc_q[CW-1:0];
				if (pop) det_q <= acc_q[DW-1:0];
			end
			B_DSET: begin
				rem_q  <= DVW'(amag) << (2 * FRAC_BITS);
				dsh_q  <= DVW'(dmag) << QB;
				qneg_q <= acof[CW-1] ^ det_q[DW-1];
				q_q    <= '0;
				sat_q  <= 1'b0;
			end
			B_DOVF: begin
				sat_q <= div_ge;
				dsh_q <= dsh_q >> 1;
			end
			B_DIV: begin
				if (div_ge) rem_q <= rem_q - dsh_q;
				q_q   <= {q_q[QW-2:0], div_ge};
				dsh_q <= dsh_q >> 1;
			end
			B_DRND: begin
				if (out_load) begin
					oval_q  <= res64[31:0];
					osing_q <= sing;
					olast_q <= (oidx_q == 4'd15);
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/core/mi4_checker.sv
// Port-level checks for matrix_inverse_4x4, attached by the bind at the end.
// Depends only on the top-level ports.
module mi4_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	logic [3:0] ocnt_q;
	logic       sing_q;
	logic       xfer;

	assign xfer = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 4'd0;
			sing_q <= 1'b0;
		end else if (xfer) begin
			ocnt_q <= ocnt_q + 4'd1;
			sing_q <= m_tuser;
		end
	end

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input changed while stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> (m_tlast == (ocnt_q == 4'd15)))
		else $error("tlast not on the sixteenth transfer");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 32'd0))
		else $error("singular result with nonzero data");

	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (ocnt_q != 4'd0) |-> (m_tuser == sing_q))
		else $error("singular flag changed within a matrix");

endmodule

bind matrix_inverse_4x4 mi4_checker u_mi4_checker (.*);

### verif/matrix_inverse_4x4_test.sv
`timescale 1ns / 1ps
// Testbench for matrix_inverse_4x4: streams 4x4 matrices in and checks every inverse element.
// It depends only on the block itself; results are predicted with wide exact arithmetic.
module matrix_inverse_4x4_test;

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic [31:0] value;
		logic        singular;
		logic        last;
	} inv_elem_t;

	typedef enum logic [1:0] {
		ROW_IDENTITY,
		ROW_EXTREMES
	} matrix_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	logic signed [31:0] loaded[16];
	int                 load_pos;
	inv_elem_t          inverse_q[$];
	int                 errors;
	int                 matrices_sent;
	int                 singular_sent;
	int                 results_seen;
	int                 out_pos;

	matrix_inverse_4x4 uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic wide_t entry(input int row, input int col);
		wide_t w;
		w = loaded[col * 4 + row];
		return w;
	endfunction

	function automatic wide_t minor3(input int skip_r, input int skip_c);
		int    rr[3];
		int    cc[3];
		int    n;
		int    m;
		wide_t v;
		n = 0;
		m = 0;
		for (int k = 0; k < 4; k++) begin
			if (k != skip_r) begin
				rr[n] = k;
				n++;
			end
			if (k != skip_c) begin
				cc[m] = k;
				m++;
			end
		end
		v = entry(rr[0], cc[0]) * (entry(rr[1], cc[1]) * entry(rr[2], cc[2])
			- entry(rr[1], cc[2]) * entry(rr[2], cc[1]));
		v = v - entry(rr[0], cc[1]) * (entry(rr[1], cc[0]) * entry(rr[2], cc[2])
			- entry(rr[1], cc[2]) * entry(rr[2], cc[0]));
		v = v + entry(rr[0], cc[2]) * (entry(rr[1], cc[0]) * entry(rr[2], cc[1])
			- entry(rr[1], cc[1]) * entry(rr[2], cc[0]));
		return ((skip_r + skip_c) % 2 == 1) ? -v : v;
	endfunction

	task automatic predict_inverse();
		wide_t     cof[4][4];
		wide_t     det;
		wide_t     dmag;
		wide_t     a;
		wide_t     q;
		wide_t     rem;
		wide_t     limit;
		logic      neg;
		inv_elem_t e;
		det = 0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				cof[r][c] = minor3(r, c);
		for (int r = 0; r < 4; r++)
			det = det + entry(r, 0) * cof[r][0];
		dmag = (det < 0) ? -det : det;
		limit = wide_t'(1) <<< 31;
		for (int k = 0; k < 16; k++) begin
			e.value = '0;
			e.singular = (det == 0);
			e.last = (k == 15);
			if (det != 0) begin
				a = cof[k / 4][k % 4];
				neg = (a < 0) != (det < 0);
				if (a < 0)
					a = -a;
				a = a <<< 32;
				q = a / dmag;
				rem = a % dmag;
				if ((rem <<< 1) >= dmag)
					q = q + 1;
				if (neg)
					q = (q <= limit) ? -q : -limit;
				else if (q >= limit)
					q = limit - 1;
				e.value = q[31:0];
			end
			inverse_q.push_back(e);
		end
		if (det == 0)
			singular_sent++;
	endtask

	task automatic send_elem(input logic [31:0] v, input int gap);
		for (int g = 0; g < gap; g++) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do
			@(posedge clk);
		while (!s_tready);
		loaded[load_pos] = v;
		load_pos++;
		if (load_pos == 16) begin
			load_pos = 0;
			matrices_sent++;
		end
	endtask

	int burst_left;
	int no_gap_stretch;

	function automatic int next_gap();
		if (no_gap_stretch > 0) begin
			no_gap_stretch--;
			return 0;
		end
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(1, 12);
		if ($urandom_range(0, 15) == 0)
			no_gap_stretch = $urandom_range(16, 64);
		return $urandom_range(1, 9);
	endfunction

	task automatic send_matrix(input logic [31:0] m[16], input logic typed_identity);
		inv_elem_t e;
		for (int k = 0; k < 16; k++) begin
			if (k == 15) begin
				if (typed_identity) begin
					for (int j = 0; j < 16; j++) begin
						e.value = (j % 5 == 0) ? 32'h0001_0000 : 32'h0;
						e.singular = 1'b0;
						e.last = (j == 15);
						inverse_q.push_back(e);
					end
				end else begin
					loaded[15] = m[15];
					predict_inverse();
				end
			end
			send_elem(m[k], next_gap());
		end
	endtask

	function automatic logic [31:0] rand_elem(input int style);
		case (style)
			0: return 32'($signed($urandom_range(0, 8191)) - 4096);
			1: return $urandom();
			2: return ($urandom_range(0, 1) == 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 262143)) - 131072);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at result %0d: %s got %h expected %h", out_pos, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_pos <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (inverse_q.size() == 0) begin
					report_mismatch("unexpected transfer", m_tdata, 32'd0);
				end else begin
					if (m_tdata !== inverse_q[0].value)
						report_mismatch("out_value", m_tdata, inverse_q[0].value);
					if (m_tuser !== inverse_q[0].singular)
						report_mismatch("singular", 32'(m_tuser), 32'(inverse_q[0].singular));
					if (m_tlast !== inverse_q[0].last)
						report_mismatch("last", 32'(m_tlast), 32'(inverse_q[0].last));
					void'(inverse_q.pop_front());
				end
				results_seen++;
				out_pos <= out_pos + 1;
			end
			if ((results_seen / 40) % 3 == 0)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", inverse_q.size());
		$display("status: fail");
		$finish;
	end

	matrix_kind_t directed_kind[2] = '{ROW_IDENTITY, ROW_EXTREMES};

	initial begin
		logic [31:0] m[16];
		int          style;
		int          wait_cycles;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		errors = 0;
		load_pos = 0;
		matrices_sent = 0;
		singular_sent = 0;
		results_seen = 0;
		burst_left = 0;
		no_gap_stretch = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_kind[i]) begin
			for (int k = 0; k < 16; k++) begin
				if (directed_kind[i] == ROW_IDENTITY)
					m[k] = (k % 5 == 0) ? 32'h0001_0000 : 32'h0;
				else
					m[k] = (k % 5 == 0) ? 32'h7fff_ffff : ((k % 3 == 0) ? 32'h8000_0000 : 32'h1);
			end
			send_matrix(m, directed_kind[i] == ROW_IDENTITY);
		end

		for (int n = 0; n < 28; n++) begin
			style = $urandom_range(0, 3);
			for (int k = 0; k < 16; k++) begin
				m[k] = rand_elem(style);
				if (style != 1 && k % 5 == 0 && $urandom_range(0, 1) == 1)
					m[k] = m[k] + 32'h0004_0000;
				if ($urandom_range(0, 31) == 0)
					m[k] = rand_elem(2);
			end
			case ($urandom_range(0, 7))
				0: for (int k = 0; k < 4; k++) m[8 + k] = m[k];
				1: for (int k = 0; k < 16; k++) m[k] = '0;
				2: for (int k = 0; k < 4; k++) m[k * 4 + 3] = 32'h0;
				default: ;
			endcase
			send_matrix(m, 1'b0);
		end
		s_tvalid <= 1'b0;

		while (inverse_q.size() != 0)
			@(posedge clk);
		wait_cycles = 50;
		repeat (wait_cycles) @(posedge clk);

		$display("sent %0d matrices (%0d singular), checked %0d inverse elements",
			matrices_sent, singular_sent, results_seen);
		if (errors == 0 && inverse_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/mi4_pkg.sv
rtl/core/mi4_front.sv
rtl/core/mi4_queue.sv
rtl/core/mi4_back.sv
rtl/core/matrix_inverse_4x4.sv
rtl/core/mi4_checker.sv
verif/matrix_inverse_4x4_test.sv
